// ----- rtl/scxk_pkg.sv -----
// Shared types, constants and register codes for the cross-kernel sharpen block.
package scxk_pkg;

    localparam int DEF_MAX_WIDTH = 4096;

    localparam int PIX_BITS      = 8;
    localparam int IMG_W_BITS    = 13;
    localparam int IMG_H_BITS    = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = IMG_W_BITS'(640);
    localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = IMG_H_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] r;
        logic [PIX_BITS-1:0] g;
        logic [PIX_BITS-1:0] b;
    } rgb_t;

    // control for one window tap cell
    typedef struct packed {
        logic shift;
        logic use_alt;
    } tap_ctrl_t;

endpackage

// ----- rtl/sharpen_cross_kernel_rgb.sv -----
// Top level of the 3x3 cross-kernel RGB sharpen block.
//
// Takes RGB pixels of one frame in raster order and returns the sharpened
// frame one row behind: the transaction carrying pixel (x,y) returns the
// result for (x,y-1), and after the frame flush transactions return the last
// row, frame_end marking its final pixel. Interior pixels get, per channel,
// 5*centre minus the up, down, left and right neighbours, clamped to 0..255;
// border pixels, and all pixels of a frame narrower or shorter than three,
// pass through. Throughput is one transaction per clock while the result is
// not stalled: each accepted transaction does one registered read on each
// line store port and at most one write, and the window over the previous
// row is a chain of two tap cells fed by the lookahead read of column x+1.
// An accepted transaction passes through the line store read register, then
// the output register, before its result is valid. A result stalled at the
// output holds; one more transaction is still taken into the read stage
// behind it. The line stores need no clearing after reset. Write image_width
// and image_height only between transactions.
module sharpen_cross_kernel_rgb #(
    parameter int MAX_WIDTH = scxk_pkg::DEF_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [scxk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [scxk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // pixel channel
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  logic                                action,
    input  logic [scxk_pkg::PIX_BITS-1:0]       red_in,
    input  logic [scxk_pkg::PIX_BITS-1:0]       green_in,
    input  logic [scxk_pkg::PIX_BITS-1:0]       blue_in,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [scxk_pkg::PIX_BITS-1:0]       red_out,
    output logic [scxk_pkg::PIX_BITS-1:0]       green_out,
    output logic [scxk_pkg::PIX_BITS-1:0]       blue_out,
    output logic                                frame_end
);
    import scxk_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);   // line store address / column count
    localparam int WW = AW + 1;              // holds the width itself

    // stage-1 control, travels with the line store read
    typedef struct packed {
        logic emit;       // transaction produces a result
        logic pixel;      // live pixel, shifts the window
        logic flush;      // live flush, result straight from the store
        logic sharp;      // interior pixel
        logic row_start;  // column zero, centre comes from the second port
        logic last;       // final pixel of the frame
        logic sel;        // store a holds the previous row
    } s1_ctrl_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_H_BITS-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_RESET;
            image_height_reg <= IMG_H_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero counts as one, width capped at the store depth
    logic [WW-1:0]         w_eff;
    logic [IMG_H_BITS-1:0] h_eff;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        h_eff = (image_height_reg == '0) ? IMG_H_BITS'(1) : image_height_reg;
    end

    // ---------------------------------------------------------------
    // frame position counters and stage 0 decode
    // ---------------------------------------------------------------
    logic [AW-1:0]         column_count_reg, column_count_next;
    logic [IMG_H_BITS-1:0] row_count_reg,    row_count_next;
    logic [AW-1:0]         flush_count_reg,  flush_count_next;
    logic                  sel_reg,          sel_next;

    logic          s1_valid_reg, s1_valid_next;
    s1_ctrl_t      s1_ctrl_reg,  s1_ctrl_next;
    rgb_t          s1_pix_reg;
    logic          s1_adv;
    logic          acc;

    logic          is_pix;
    logic          pix_live;
    logic          flush_live;
    logic [WW-1:0] x_inc;
    logic [WW-1:0] fc_inc;
    logic          row_wrap;
    logic          flush_last;
    logic          sharp0;
    rgb_t          pix_in;

    assign pix_in     = '{r: red_in, g: green_in, b: blue_in};
    assign is_pix     = (action_t'(action) == ACT_PIXEL);
    assign pix_live   = is_pix && (row_count_reg < h_eff);
    assign flush_live = !is_pix && (row_count_reg >= h_eff);
    assign x_inc      = {1'b0, column_count_reg} + WW'(1);
    assign fc_inc     = {1'b0, flush_count_reg} + WW'(1);
    assign row_wrap   = (x_inc >= w_eff);
    assign flush_last = (fc_inc >= w_eff);
    assign sharp0     = (w_eff >= WW'(3)) && (h_eff >= IMG_H_BITS'(3))
                     && (row_count_reg >= IMG_H_BITS'(2))
                     && (column_count_reg != '0) && (x_inc < w_eff);

    // the read stage moves on when the output register is free or draining
    assign s1_adv    = !res_valid || !res_stall;
    assign pix_stall = s1_valid_reg && !s1_adv;
    assign acc       = pix_valid && !pix_stall;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        flush_count_next  = flush_count_reg;
        sel_next          = sel_reg;
        if (acc && pix_live)
        begin
            if (row_wrap)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + IMG_H_BITS'(1);
                sel_next          = !sel_reg;
            end
            else
            begin
                column_count_next = x_inc[AW-1:0];
            end
        end
        else if (acc && flush_live)
        begin
            if (flush_last)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                flush_count_next  = '0;
                sel_next          = 1'b0;
            end
            else
            begin
                flush_count_next = fc_inc[AW-1:0];
            end
        end

        s1_ctrl_next.emit      = (pix_live && (row_count_reg != '0)) || flush_live;
        s1_ctrl_next.pixel     = pix_live;
        s1_ctrl_next.flush     = flush_live;
        s1_ctrl_next.sharp     = sharp0;
        s1_ctrl_next.row_start = (column_count_reg == '0);
        s1_ctrl_next.last      = flush_live && flush_last;
        s1_ctrl_next.sel       = sel_reg;

        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            flush_count_reg  <= '0;
            sel_reg          <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_ctrl_reg      <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            flush_count_reg  <= flush_count_next;
            sel_reg          <= sel_next;
            s1_valid_reg     <= s1_valid_next;
            if (acc)
            begin
                s1_ctrl_reg <= s1_ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg <= pix_in;
        end
    end

    // ---------------------------------------------------------------
    // line stores
    // port 0: previous row at x+1 (lookahead) or older row at x
    // port 1: previous row at x, or at the flush position
    // ---------------------------------------------------------------
    logic [AW-1:0] rd1_addr;
    logic [AW-1:0] a_rd0_addr, b_rd0_addr;
    logic          a_we, b_we;
    rgb_t          a_rd0, a_rd1, b_rd0, b_rd1;

    assign rd1_addr   = flush_live ? flush_count_reg : column_count_reg;
    assign a_rd0_addr = sel_reg ? x_inc[AW-1:0] : column_count_reg;
    assign b_rd0_addr = sel_reg ? column_count_reg : x_inc[AW-1:0];
    // the incoming pixel overwrites the older row
    assign a_we       = acc && pix_live && !sel_reg;
    assign b_we       = acc && pix_live && sel_reg;

    scxk_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_store_a (
        .clk      (clk),
        .we       (a_we),
        .wr_addr  (column_count_reg),
        .wr_data  (pix_in),
        .rd_en    (acc),
        .rd0_addr (a_rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (a_rd0),
        .rd1_data (a_rd1)
    );

    scxk_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_store_b (
        .clk      (clk),
        .we       (b_we),
        .wr_addr  (column_count_reg),
        .wr_data  (pix_in),
        .rd_en    (acc),
        .rd0_addr (b_rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (b_rd0),
        .rd1_data (b_rd1)
    );

    // ---------------------------------------------------------------
    // stage 1: window over the previous row, kernel, result select
    // ---------------------------------------------------------------
    rgb_t      prev_right;
    rgb_t      prev_here;
    rgb_t      older_up;
    rgb_t      centre;
    rgb_t      left;
    rgb_t      sharp;
    rgb_t      result;
    tap_ctrl_t centre_ctrl;
    tap_ctrl_t left_ctrl;
    logic      win_shift;

    assign prev_right = s1_ctrl_reg.sel ? a_rd0 : b_rd0;
    assign prev_here  = s1_ctrl_reg.sel ? a_rd1 : b_rd1;
    assign older_up   = s1_ctrl_reg.sel ? b_rd0 : a_rd0;

    // window slides one column per live pixel leaving the read stage
    assign win_shift   = s1_valid_reg && s1_adv && s1_ctrl_reg.pixel;
    assign centre_ctrl = '{shift: win_shift, use_alt: s1_ctrl_reg.row_start};
    assign left_ctrl   = '{shift: win_shift, use_alt: 1'b0};

    scxk_tap u_tap_centre (
        .clk   (clk),
        .ctrl  (centre_ctrl),
        .nbr_d (prev_right),
        .alt_d (prev_here),
        .tap   (centre)
    );

    scxk_tap u_tap_left (
        .clk   (clk),
        .ctrl  (left_ctrl),
        .nbr_d (centre),
        .alt_d (prev_here),
        .tap   (left)
    );

    scxk_lane u_lane_r (
        .centre (centre.r),
        .up     (older_up.r),
        .down   (s1_pix_reg.r),
        .left   (left.r),
        .right  (prev_right.r),
        .sharp  (sharp.r)
    );

    scxk_lane u_lane_g (
        .centre (centre.g),
        .up     (older_up.g),
        .down   (s1_pix_reg.g),
        .left   (left.g),
        .right  (prev_right.g),
        .sharp  (sharp.g)
    );

    scxk_lane u_lane_b (
        .centre (centre.b),
        .up     (older_up.b),
        .down   (s1_pix_reg.b),
        .left   (left.b),
        .right  (prev_right.b),
        .sharp  (sharp.b)
    );

    always_comb
    begin
        if (s1_ctrl_reg.flush)
        begin
            result = prev_here;
        end
        else if (s1_ctrl_reg.sharp)
        begin
            result = sharp;
        end
        else
        begin
            result = centre;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic res_valid_reg, res_valid_next;
    rgb_t res_pix_reg;
    logic frame_end_reg;
    logic out_load;

    assign out_load       = s1_valid_reg && s1_adv && s1_ctrl_reg.emit;
    assign res_valid_next = out_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_pix_reg   <= result;
            frame_end_reg <= s1_ctrl_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign red_out   = res_pix_reg.r;
    assign green_out = res_pix_reg.g;
    assign blue_out  = res_pix_reg.b;
    assign frame_end = frame_end_reg;

`ifndef SYNTHESIS
    // the closing flush rearms the frame position
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && flush_live && flush_last) |=>
            (row_count_reg == '0 && column_count_reg == '0
             && flush_count_reg == '0 && !sel_reg))
        else $error("frame counters not cleared after last flush");

    // a held read stage keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=>
            (s1_valid_reg && $stable(s1_pix_reg) && $stable(s1_ctrl_reg)))
        else $error("read stage lost a held transaction");

    // a newly raised result comes from an emitting transaction in the read stage
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg && s1_ctrl_reg.emit))
        else $error("result raised without a source transaction");
`endif

endmodule

// ----- rtl/scxk_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module scxk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd0_data,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    // read-first: a same-edge write is not seen by the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg <= mem[rd0_addr];
            rd1_reg <= mem[rd1_addr];
        end
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd0_data = rd0_reg;
    assign rd1_data = rd1_reg;

endmodule

// ----- rtl/scxk_tap.sv -----
// Window tap cell: holds one pixel of the previous row, shifts from its neighbour.
module scxk_tap (
    input  logic                clk,
    input  scxk_pkg::tap_ctrl_t ctrl,
    input  scxk_pkg::rgb_t      nbr_d,
    input  scxk_pkg::rgb_t      alt_d,
    output scxk_pkg::rgb_t      tap
);
    import scxk_pkg::*;

    rgb_t q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            q_reg <= nbr_d;
        end
    end

    // alternate source injects the row's first pixel
    assign tap = ctrl.use_alt ? alt_d : q_reg;

endmodule

// ----- rtl/scxk_lane.sv -----
// One colour lane: 5*centre minus four neighbours, clamped to the pixel range.
module scxk_lane (
    input  logic [scxk_pkg::PIX_BITS-1:0] centre,
    input  logic [scxk_pkg::PIX_BITS-1:0] up,
    input  logic [scxk_pkg::PIX_BITS-1:0] down,
    input  logic [scxk_pkg::PIX_BITS-1:0] left,
    input  logic [scxk_pkg::PIX_BITS-1:0] right,
    output logic [scxk_pkg::PIX_BITS-1:0] sharp
);
    import scxk_pkg::*;

    localparam int SW = PIX_BITS + 4;

    logic signed [SW-1:0] times5;
    logic signed [SW-1:0] nsum;
    logic signed [SW-1:0] diff;

    assign times5 = $signed(SW'({centre, 2'b00})) + $signed(SW'(centre));
    assign nsum   = $signed(SW'(up)) + $signed(SW'(down))
                  + $signed(SW'(left)) + $signed(SW'(right));
    assign diff   = times5 - nsum;

    always_comb
    begin
        if (diff < 0)
        begin
            sharp = '0;
        end
        else if (diff > $signed(SW'({PIX_BITS{1'b1}})))
        begin
            sharp = {PIX_BITS{1'b1}};
        end
        else
        begin
            sharp = diff[PIX_BITS-1:0];
        end
    end

endmodule

// ----- verif/cross_sharpen_checker.sv -----
// Checker for the cross-kernel sharpen block: tracks its line stores and compares results.
module cross_sharpen_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scxk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [scxk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                pix_valid,
    input  logic                                pix_stall,
    input  logic                                action,
    input  logic [scxk_pkg::PIX_BITS-1:0]       red_in,
    input  logic [scxk_pkg::PIX_BITS-1:0]       green_in,
    input  logic [scxk_pkg::PIX_BITS-1:0]       blue_in,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  logic [scxk_pkg::PIX_BITS-1:0]       red_out,
    input  logic [scxk_pkg::PIX_BITS-1:0]       green_out,
    input  logic [scxk_pkg::PIX_BITS-1:0]       blue_out,
    input  logic                                frame_end,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import scxk_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH;

    typedef struct {
        rgb_t pix;
        logic last;
    } out_pixel_t;

    rgb_t                  row_buf_a [STORE_DEPTH];
    rgb_t                  row_buf_b [STORE_DEPTH];
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    int unsigned           col_pos;
    logic [IMG_H_BITS-1:0] row_pos;
    logic                  swap;
    int unsigned           drain_pos;
    int unsigned           results_seen;
    out_pixel_t            expected_pixels [$];
    out_pixel_t            want;

    function automatic int unsigned active_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > STORE_DEPTH)
            return STORE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    // swap set: store a holds the row above, store b the row before that
    function automatic rgb_t row_above(int unsigned i);
        return swap ? row_buf_a[i] : row_buf_b[i];
    endfunction

    function automatic rgb_t row_two_up(int unsigned i);
        return swap ? row_buf_b[i] : row_buf_a[i];
    endfunction

    function automatic rgb_t cross_filter(rgb_t c, rgb_t u, rgb_t d, rgb_t l, rgb_t r);
        rgb_t res;
        int   v;
        for (int k = 0; k < 3; k++) begin
            v = 5 * int'(c[8*k +: 8]) - int'(u[8*k +: 8]) - int'(d[8*k +: 8])
                - int'(l[8*k +: 8]) - int'(r[8*k +: 8]);
            res[8*k +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch @%0t result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic take_transaction(action_t act, rgb_t px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        out_pixel_t  o;
        w = active_width();
        h = active_height();
        if (act == ACT_PIXEL) begin
            if (row_pos >= h)
                return;
            x = col_pos;
            if (row_pos >= 1) begin
                o.pix  = row_above(x);
                o.last = 1'b0;
                if (w >= 3 && h >= 3 && row_pos >= 2 && x >= 1 && x + 1 < w)
                    o.pix = cross_filter(o.pix, row_two_up(x), px,
                                         row_above(x - 1), row_above(x + 1));
                expected_pixels.push_back(o);
            end
            if (swap)
                row_buf_b[x] = px;
            else
                row_buf_a[x] = px;
            col_pos = x + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                swap    = ~swap;
            end
        end
        else begin
            if (row_pos < h)
                return;
            drain_pos++;
            o.pix  = row_above(drain_pos - 1);
            o.last = (drain_pos >= w);
            expected_pixels.push_back(o);
            if (o.last) begin
                col_pos   = 0;
                row_pos   = '0;
                swap      = 1'b0;
                drain_pos = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg    = IMG_W_RESET;
            height_reg   = IMG_H_RESET;
            col_pos      = 0;
            row_pos      = '0;
            swap         = 1'b0;
            drain_pos    = 0;
            results_seen = 0;
            expected_pixels.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data[IMG_W_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_H_BITS-1:0];
                    default: ;
                endcase
            end
            if (res_valid && !res_stall) begin
                if (expected_pixels.size() == 0)
                    flag_mismatch("result with nothing expected");
                else begin
                    want = expected_pixels.pop_front();
                    if (red_out !== want.pix.r)
                        flag_mismatch($sformatf("red %0d, want %0d", red_out, want.pix.r));
                    if (green_out !== want.pix.g)
                        flag_mismatch($sformatf("green %0d, want %0d", green_out, want.pix.g));
                    if (blue_out !== want.pix.b)
                        flag_mismatch($sformatf("blue %0d, want %0d", blue_out, want.pix.b));
                    if (frame_end !== want.last)
                        flag_mismatch($sformatf("frame_end %b, want %b", frame_end, want.last));
                end
                results_seen++;
            end
            if (pix_valid && !pix_stall)
                take_transaction(action_t'(action), rgb_t'({red_in, green_in, blue_in}));
            outstanding = expected_pixels.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the cross-kernel sharpen block: stimulus, stall pattern and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scxk_pkg::*;

    // generous bound covering every transaction, the stalls and the settling
    localparam int CYCLE_LIMIT  = 40_000;
    localparam int RANDOM_ITEMS = 440;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     pix_valid = 1'b0;
    logic                     pix_stall;
    logic                     action    = 1'b0;
    logic [PIX_BITS-1:0]      red_in    = '0;
    logic [PIX_BITS-1:0]      green_in  = '0;
    logic [PIX_BITS-1:0]      blue_in   = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [PIX_BITS-1:0]      red_out;
    logic [PIX_BITS-1:0]      green_out;
    logic [PIX_BITS-1:0]      blue_out;
    logic                     frame_end;
    int                       mismatches;
    int                       outstanding;
    int                       cycles    = 0;
    // calm: neither side idles, so the pipeline runs back to back
    bit                       calm      = 1'b0;

    sharpen_cross_kernel_rgb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .action    (action),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    cross_sharpen_checker sharpen_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .action      (action),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .frame_end   (frame_end),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure: roughly one cycle in four, none while calm
    always @(negedge clk)
    begin
        res_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // channel values biased towards 0 and 255 so both clamps get hit often
    function automatic rgb_t rand_pixel();
        rgb_t p;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 3))
                0:       p[8*k +: 8] = 8'h00;
                1:       p[8*k +: 8] = 8'hFF;
                default: p[8*k +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    // One transaction. Inputs move on the falling edge; returns at the rising
    // edge that accepted it, leaving valid high until the next falling edge.
    task automatic send_txn(action_t act, rgb_t px);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            pix_valid = 1'b0;
            @(negedge clk);
        end
        pix_valid = 1'b1;
        action    = act;
        red_in    = px.r;
        green_in  = px.g;
        blue_in   = px.b;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++)
            send_txn(ACT_PIXEL, rand_pixel());
    endtask

    // flush payload is ignored by the block, so random content is harmless
    task automatic send_flushes(int n);
        for (int i = 0; i < n; i++)
            send_txn(ACT_FLUSH, rand_pixel());
    endtask

    // Whole frame with some noise: stray early flushes (ignored while the frame
    // is incomplete) and now and then surplus pixels once it is complete.
    task automatic noisy_frame(int w, int h);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_txn(ACT_FLUSH, rand_pixel());
            send_txn(ACT_PIXEL, rand_pixel());
        end
        if ($urandom_range(0, 4) == 0)
            send_pixels($urandom_range(1, 2));
        send_flushes(w);
    endtask

    // Sender holds off until every predicted result has come back, then allows
    // the pipeline to finish any transaction that produced nothing.
    task automatic settle();
        @(negedge clk);
        pix_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        int w;
        int h;
        int sent;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 4x3 frame; bits above the 13-bit width field must be dropped
        write_reg(REG_IMAGE_WIDTH, 16'hE004);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_txn(ACT_FLUSH, rand_pixel());          // early flush, ignored
        // a lone bright pixel at (1,1): it clamps high, its dark neighbour
        // at (2,1) clamps low
        for (int i = 0; i < 12; i++)
            send_txn(ACT_PIXEL, rgb_t'({24{i == 5}}));
        send_txn(ACT_PIXEL, rand_pixel());          // frame already full, ignored
        send_flushes(4);

        // zero width and zero height both count as one
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        send_pixels(1);
        send_flushes(1);

        // width cut mid-row: column 6 of 8 becomes past the end of a 4-wide row
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        send_pixels(14);
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        send_pixels(9);
        send_flushes(4);

        // tallest frame, cut short mid-frame by a height change
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_pixels(12);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        send_pixels(4);
        send_flushes(4);

        // widest width field: no wrap within the first row until it is cut to four
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_pixels(6);
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        send_pixels(9);
        send_flushes(4);

        // random frames, mostly small; some run back to back with no reconfig
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(25, 64);
                    1, 2:    w = $urandom_range(9, 24);
                    default: w = $urandom_range(1, 8);
                endcase
                h = $urandom_range(1, 6);
                settle();
                write_reg(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(0, 1) == 1) ?
                          16'd0 : {3'($urandom), 13'(w)});
                write_reg(REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(0, 1) == 1) ?
                          16'd0 : 16'(h));
            end
            calm = (sent >= 150 && sent < 320);
            noisy_frame(w, h);
            sent += w * h + w;
        end
        calm = 1'b0;

        @(negedge clk);
        pix_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
